// File: rtl/core/itam_pkg.sv
// ----------------------------------------------------------------------------
// itam_pkg
// Shared types, register map and defaults for the inrush and threshold
// alarm monitor.
// ----------------------------------------------------------------------------
package itam_pkg;

    localparam int unsigned INRUSH_WINDOW_MS_DEF = 100;
    localparam int unsigned COOLDOWN_MS_DEF      = 1000;

    localparam int CFG_AW = 5;

    localparam logic [2:0] REG_INRUSH_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_AMBIENT_TEMP     = 3'd1;
    localparam logic [2:0] REG_TEMP_WARN        = 3'd2;
    localparam logic [2:0] REG_TEMP_CRIT        = 3'd3;
    localparam logic [2:0] REG_DT_WARN          = 3'd4;
    localparam logic [2:0] REG_DT_CRIT          = 3'd5;
    localparam logic [2:0] REG_VIB_WARN         = 3'd6;
    localparam logic [2:0] REG_VIB_CRIT         = 3'd7;

    typedef logic [1:0] level_t;

    localparam level_t LVL_NONE = 2'd0;
    localparam level_t LVL_WARN = 2'd1;
    localparam level_t LVL_CRIT = 2'd2;

    typedef struct packed {
        logic        [15:0] inrush_threshold;
        logic signed [12:0] ambient_temp;
        logic signed [12:0] temp_warn;
        logic signed [12:0] temp_crit;
        logic signed [13:0] dt_warn;
        logic signed [13:0] dt_crit;
        logic        [15:0] vib_warn;
        logic        [15:0] vib_crit;
    } cfg_t;

    typedef struct packed {
        logic        [31:0] now_ms;
        logic        [15:0] primary_peak;
        logic signed [12:0] core_temp;
        logic               temp_valid;
        logic        [15:0] vibration_120hz;
        logic               vib_valid;
    } sample_t;

    typedef struct packed {
        logic signed [13:0] delta_temp;
        level_t             temp_level;
        level_t             dt_level;
        level_t             vib_level;
    } levels_t;

    typedef struct packed {
        logic        detected;
        logic [15:0] peak;
    } inrush_t;

endpackage

// File: rtl/core/itam_regs.sv
// ----------------------------------------------------------------------------
// itam_regs
// APB-style configuration register file for thresholds and ambient.
// ----------------------------------------------------------------------------
module itam_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [itam_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output itam_pkg::cfg_t             cfg
);
    import itam_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_INRUSH_THRESHOLD: cfg_next.inrush_threshold = pwdata[15:0];
                REG_AMBIENT_TEMP:     cfg_next.ambient_temp     = pwdata[12:0];
                REG_TEMP_WARN:        cfg_next.temp_warn        = pwdata[12:0];
                REG_TEMP_CRIT:        cfg_next.temp_crit        = pwdata[12:0];
                REG_DT_WARN:          cfg_next.dt_warn          = pwdata[13:0];
                REG_DT_CRIT:          cfg_next.dt_crit          = pwdata[13:0];
                REG_VIB_WARN:         cfg_next.vib_warn         = pwdata[15:0];
                REG_VIB_CRIT:         cfg_next.vib_crit         = pwdata[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_INRUSH_THRESHOLD: prdata = {16'd0, cfg_reg.inrush_threshold};
            REG_AMBIENT_TEMP:     prdata = 32'($signed(cfg_reg.ambient_temp));
            REG_TEMP_WARN:        prdata = 32'($signed(cfg_reg.temp_warn));
            REG_TEMP_CRIT:        prdata = 32'($signed(cfg_reg.temp_crit));
            REG_DT_WARN:          prdata = 32'($signed(cfg_reg.dt_warn));
            REG_DT_CRIT:          prdata = 32'($signed(cfg_reg.dt_crit));
            REG_VIB_WARN:         prdata = {16'd0, cfg_reg.vib_warn};
            REG_VIB_CRIT:         prdata = {16'd0, cfg_reg.vib_crit};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inrush_threshold <= 16'd2000;
            cfg_reg.ambient_temp     <= 13'sd400;
            cfg_reg.temp_warn        <= 13'sd1280;
            cfg_reg.temp_crit        <= 13'sd1600;
            cfg_reg.dt_warn          <= 14'sd640;
            cfg_reg.dt_crit          <= 14'sd960;
            cfg_reg.vib_warn         <= 16'd500;
            cfg_reg.vib_crit         <= 16'd1000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/itam_levels.sv
// ----------------------------------------------------------------------------
// itam_levels
// Delta-T and three-level alarm classification for temperature, delta-T
// and vibration.
// ----------------------------------------------------------------------------
module itam_levels (
    input  itam_pkg::sample_t smp,
    input  itam_pkg::cfg_t    cfg,
    output itam_pkg::levels_t lvl
);
    import itam_pkg::*;

    logic signed [13:0] dt;

    function automatic level_t level_s(input logic signed [13:0] v,
                                       input logic signed [13:0] warn,
                                       input logic signed [13:0] crit);
        level_t l;
        if (v >= crit) begin
            l = LVL_CRIT;
        end else if (v >= warn) begin
            l = LVL_WARN;
        end else begin
            l = LVL_NONE;
        end
        return l;
    endfunction

    assign dt = 14'($signed(smp.core_temp)) - 14'($signed(cfg.ambient_temp));

    always_comb begin
        lvl = '0;
        if (smp.temp_valid) begin
            lvl.delta_temp = dt;
            lvl.temp_level = level_s(14'($signed(smp.core_temp)),
                                     14'($signed(cfg.temp_warn)),
                                     14'($signed(cfg.temp_crit)));
            lvl.dt_level   = level_s(dt, $signed(cfg.dt_warn), $signed(cfg.dt_crit));
        end
        if (smp.vib_valid) begin
            if (smp.vibration_120hz >= cfg.vib_crit) begin
                lvl.vib_level = LVL_CRIT;
            end else if (smp.vibration_120hz >= cfg.vib_warn) begin
                lvl.vib_level = LVL_WARN;
            end else begin
                lvl.vib_level = LVL_NONE;
            end
        end
    end

endmodule

// File: rtl/core/itam_detector.sv
// ----------------------------------------------------------------------------
// itam_detector
// Inrush detector: idle, monitoring window with peak tracking, cooldown.
// ----------------------------------------------------------------------------
module itam_detector #(
    parameter int unsigned INRUSH_WINDOW_MS = itam_pkg::INRUSH_WINDOW_MS_DEF,
    parameter int unsigned COOLDOWN_MS      = itam_pkg::COOLDOWN_MS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [31:0]        now_ms,
    input  logic [15:0]        primary_peak,
    input  logic [15:0]        threshold,
    output itam_pkg::inrush_t  result
);
    import itam_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MON  = 2'd1;
    localparam logic [1:0] ST_COOL = 2'd2;

    logic [1:0]  state_reg,    state_next;
    logic [31:0] win_start_reg, win_start_next;
    logic [31:0] cool_start_reg, cool_start_next;
    logic [15:0] peak_reg,     peak_next;
    logic [15:0] peak_max;
    logic [31:0] win_elapsed;
    logic [31:0] cool_elapsed;

    assign win_elapsed  = now_ms - win_start_reg;
    assign cool_elapsed = now_ms - cool_start_reg;
    assign peak_max     = (primary_peak > peak_reg) ? primary_peak : peak_reg;

    always_comb begin
        state_next      = state_reg;
        win_start_next  = win_start_reg;
        cool_start_next = cool_start_reg;
        peak_next       = peak_reg;
        result          = '0;
        unique case (state_reg)
            ST_MON: begin
                peak_next = peak_max;
                if (win_elapsed >= 32'(INRUSH_WINDOW_MS)) begin
                    result.detected = 1'b1;
                    result.peak     = peak_max;
                    state_next      = ST_COOL;
                    cool_start_next = now_ms;
                end
            end
            ST_COOL: begin
                if (cool_elapsed >= 32'(COOLDOWN_MS)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                if (primary_peak >= threshold) begin
                    state_next     = ST_MON;
                    win_start_next = now_ms;
                    peak_next      = primary_peak;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            win_start_reg  <= '0;
            cool_start_reg <= '0;
            peak_reg       <= '0;
        end else if (step) begin
            state_reg      <= state_next;
            win_start_reg  <= win_start_next;
            cool_start_reg <= cool_start_next;
            peak_reg       <= peak_next;
        end
    end

    a_det_only_in_mon: assert property (@(posedge aclk) disable iff (!aresetn)
        result.detected |-> state_reg == ST_MON)
        else $error("detection outside monitoring window");

    a_det_enters_cool: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.detected |=> state_reg == ST_COOL)
        else $error("closed window did not enter cooldown");

    a_open_window: assert property (@(posedge aclk) disable iff (!aresetn)
        step && state_reg == ST_IDLE && primary_peak >= threshold
        |=> state_reg == ST_MON && peak_reg == $past(primary_peak))
        else $error("window did not open on threshold crossing");

    a_hold_when_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(state_reg) && $stable(peak_reg))
        else $error("detector state moved without a sample");

endmodule

// File: rtl/core/inrush_and_threshold_alarm_monitor_unit.sv
// ----------------------------------------------------------------------------
// inrush_and_threshold_alarm_monitor_unit
// Per-sample inrush detection and temperature / delta-T / vibration alarms.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output is not stalled by m_ready, and
// returns one result per sample, in order. Each sample is held in the input
// register, where delta-T, the alarm levels and the detector step are worked
// out, and then moves into the result register, which drives the outputs.
// The detector state advances as a sample moves into the result register, so
// back-to-back samples see each other's state updates without bubbles.
// Configuration should be written while no sample is in flight.
module inrush_and_threshold_alarm_monitor_unit #(
    parameter int unsigned INRUSH_WINDOW_MS = itam_pkg::INRUSH_WINDOW_MS_DEF,
    parameter int unsigned COOLDOWN_MS      = itam_pkg::COOLDOWN_MS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [itam_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [31:0]                 s_now_ms,
    input  logic [15:0]                 s_primary_peak,
    input  logic signed [12:0]          s_core_temp,
    input  logic                        s_temp_valid,
    input  logic [15:0]                 s_vibration_120hz,
    input  logic                        s_vib_valid,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [13:0]          m_delta_temp,
    output itam_pkg::level_t            m_temp_level,
    output itam_pkg::level_t            m_dt_level,
    output itam_pkg::level_t            m_vib_level,
    output logic                        m_inrush_detected,
    output logic [15:0]                 m_inrush_peak
);
    import itam_pkg::*;

    cfg_t    cfg;
    sample_t smp_reg;
    logic    smp_valid_reg;
    levels_t lvl;
    inrush_t inr;
    levels_t lvl_out_reg;
    inrush_t inr_out_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance = smp_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !smp_valid_reg || advance;

    itam_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    itam_levels u_levels (
        .smp (smp_reg),
        .cfg (cfg),
        .lvl (lvl)
    );

    itam_detector #(
        .INRUSH_WINDOW_MS (INRUSH_WINDOW_MS),
        .COOLDOWN_MS      (COOLDOWN_MS)
    ) u_detector (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .now_ms       (smp_reg.now_ms),
        .primary_peak (smp_reg.primary_peak),
        .threshold    (cfg.inrush_threshold),
        .result       (inr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                smp_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            smp_reg.now_ms          <= s_now_ms;
            smp_reg.primary_peak    <= s_primary_peak;
            smp_reg.core_temp       <= s_core_temp;
            smp_reg.temp_valid      <= s_temp_valid;
            smp_reg.vibration_120hz <= s_vibration_120hz;
            smp_reg.vib_valid       <= s_vib_valid;
        end
        if (advance) begin
            lvl_out_reg <= lvl;
            inr_out_reg <= inr;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_delta_temp      = lvl_out_reg.delta_temp;
    assign m_temp_level      = lvl_out_reg.temp_level;
    assign m_dt_level        = lvl_out_reg.dt_level;
    assign m_vib_level       = lvl_out_reg.vib_level;
    assign m_inrush_detected = inr_out_reg.detected;
    assign m_inrush_peak     = inr_out_reg.peak;

endmodule
